// File: hdl/lgs_pkg.sv
package lgs_pkg;

  // field widths of the register and the window
  localparam int unsigned GRID_LEN_W      = 6;
  localparam int unsigned GRID_LEN_RESET  = 10;
  localparam int unsigned MAX_LEN_DEFAULT = 32;
  localparam int unsigned WIN_W           = 9;
  localparam int unsigned CNT_W           = 4;

  // rule thresholds: birth on three, survival on two or three
  localparam logic [CNT_W-1:0] BIRTH_CNT = CNT_W'(3);
  localparam logic [CNT_W-1:0] KEEP_CNT  = CNT_W'(2);

  // centre of the window is bit 4, the eight others are neighbours
  function automatic logic next_cell(input logic [WIN_W-1:0] win);
    logic [CNT_W-1:0] cnt;
    logic             res;
    cnt = '0;
    for (int b = 0; b < WIN_W; b++) begin
      if (b != 4) begin
        cnt = cnt + CNT_W'(win[b]);
      end
    end
    if (cnt == BIRTH_CNT) begin
      res = 1'b1;
    end else if (cnt == KEEP_CNT) begin
      res = win[4];
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: hdl/lgs_front.sv
module lgs_front import lgs_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT,
  parameter int unsigned RW      = $clog2(MAX_LEN + 2),
  parameter int unsigned CW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  parameter int unsigned EW      = 2 + RW + CW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic [RW-1:0] len_i,
  input  logic          in_valid_i,
  input  logic          cell_alive_i,
  input  logic          q_full_i,
  output logic          in_stall_o,
  output logic          q_push_o,
  output logic [EW-1:0] q_data_o
);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          accept;
  logic          last_col;
  logic          last_cell;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign last_col   = (RW'(col_q) == len_i - RW'(1));
  assign last_cell  = last_col && (row_q == len_i - RW'(1));

  // entry: cell, grid end mark, row, column
  assign q_push_o = accept;
  assign q_data_o = {cell_alive_i, last_cell, row_q, col_q};

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (clear_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_cell ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// File: hdl/lgs_queue.sv
module lgs_queue import lgs_pkg::*; #(
  parameter int unsigned EW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          push_i,
  input  logic [EW-1:0] push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output logic [EW-1:0] data_o,
  input  logic          pop_i
);

  // two entries
  logic [EW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else if (clear_i) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: hdl/lgs_back.sv
module lgs_back import lgs_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT,
  parameter int unsigned RW      = $clog2(MAX_LEN + 2),
  parameter int unsigned CW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  parameter int unsigned EW      = 2 + RW + CW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic [RW-1:0] len_i,
  input  logic          q_valid_i,
  input  logic [EW-1:0] q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          next_alive_o,
  output logic          grid_last_o
);

  // line buffers, rows masked by row position instead of cleared
  logic [MAX_LEN-1:0] upper_q;
  logic [MAX_LEN-1:0] middle_q;
  logic [WIN_W-1:0]   win_q, win_d;

  logic          flush_q;
  logic [RW-1:0] fl_row_q;
  logic [CW-1:0] fl_col_q;

  logic          out_valid_q, next_alive_q, grid_last_q;

  logic          q_bit, q_last;
  logic [RW-1:0] q_row;
  logic [CW-1:0] q_col;

  logic          adv, do_push;
  logic          src_bit;
  logic [RW-1:0] src_row;
  logic [CW-1:0] src_col;
  logic          top_raw, mid_raw;
  logic [2:0]    column;
  logic [WIN_W-1:0] win_emit;
  logic          emit, emit_last;
  logic [RW-1:0] len_p1;

  assign {q_bit, q_last, q_row, q_col} = q_data_i;
  assign len_p1 = len_i + RW'(1);

  assign adv     = !out_valid_q || !out_stall_i;
  assign q_pop_o = adv && !flush_q && q_valid_i && !clear_i;
  assign do_push = q_pop_o || (adv && flush_q && !clear_i);

  // flush pushes dead cells: one row below the grid, then one more cell
  assign src_bit = flush_q ? 1'b0 : q_bit;
  assign src_row = flush_q ? fl_row_q : q_row;
  assign src_col = flush_q ? fl_col_q : q_col;

  assign top_raw = upper_q[src_col];
  assign mid_raw = middle_q[src_col];
  assign column  = {src_bit, mid_raw && (src_row != '0), top_raw && (src_row >= RW'(2))};

  always_comb begin
    if (src_col == '0) begin
      // close out the previous row with a dead right edge
      win_emit  = {3'b000, win_q[WIN_W-1:3]};
      win_d     = {column, 6'b000000};
      emit      = (src_row >= RW'(2));
      emit_last = (src_row == len_p1);
    end else begin
      win_d     = {column, win_q[WIN_W-1:3]};
      win_emit  = win_d;
      emit      = (src_row != '0);
      emit_last = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      upper_q[src_col]  <= mid_raw;
      middle_q[src_col] <= src_bit;
    end
    if (do_push && emit) begin
      next_alive_q <= next_cell(win_emit);
      grid_last_q  <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (do_push) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q  <= 1'b0;
      fl_row_q <= '0;
      fl_col_q <= '0;
    end else if (clear_i) begin
      flush_q  <= 1'b0;
      fl_row_q <= '0;
      fl_col_q <= '0;
    end else if (q_pop_o && q_last) begin
      flush_q  <= 1'b1;
      fl_row_q <= len_i;
      fl_col_q <= '0;
    end else if (flush_q && adv) begin
      if (fl_row_q == len_p1) begin
        flush_q <= 1'b0;
      end else if (RW'(fl_col_q) == len_i - RW'(1)) begin
        fl_row_q <= len_p1;
        fl_col_q <= '0;
      end else begin
        fl_col_q <= fl_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_push) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = next_alive_q;
  assign grid_last_o  = grid_last_q;

endmodule

// File: hdl/life_generation_stencil_unit.sv
// one generation of a square life grid (birth on 3, survival on 2 or 3), computed as a
// stream. cells of the current generation enter one per beat in raster order and the
// next-generation cells leave in raster order, one row plus one cell behind the input;
// grid_last_o marks the final cell. cells outside the grid are dead and edges do not wrap.
// the block takes one cell per cycle unless in_stall_o is high: a front stage tags each
// cell with its position, a two-entry queue decouples it from the back stage, which runs
// the line buffers, the 3x3 window and the rule, one window step per cycle. after the
// last cell of a grid the back stage pushes dead cells to flush the final row; the queue
// takes one more cell meanwhile, and since its full flag frees only after the first pop,
// the input stalls until the flush is over. output stalls hold the back stage as well.
// the user must write grid_len_i through the cfg channel only while the block is idle;
// the block itself does not enforce it. a write clears the grid position, so a new grid
// starts with the next cell. a length of 0 acts as 1 and one above MAX_LEN acts as MAX_LEN.
module life_generation_stencil_unit import lgs_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [GRID_LEN_W-1:0] grid_len_i,
  // cell input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cell_alive_i,
  // next-generation output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  next_alive_o,
  output logic                  grid_last_o
);

  localparam int unsigned RW = $clog2(MAX_LEN + 2);
  localparam int unsigned CW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned EW = 2 + RW + CW;
  localparam int unsigned LEN_RST = (GRID_LEN_RESET > MAX_LEN) ? MAX_LEN : GRID_LEN_RESET;

  logic          cfg_fire;
  logic [RW-1:0] len_q, len_d;

  logic          q_full, q_push, q_valid, q_pop;
  logic [EW-1:0] q_wdata, q_rdata;

  // config is always taken; writes must happen only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // effective side length, clamped to 1..MAX_LEN
  always_comb begin
    if (grid_len_i == '0) begin
      len_d = RW'(1);
    end else if (7'(grid_len_i) > 7'(MAX_LEN)) begin
      len_d = RW'(MAX_LEN);
    end else begin
      len_d = RW'(grid_len_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= RW'(LEN_RST);
    end else if (cfg_fire) begin
      len_q <= len_d;
    end
  end

  // front: raster position and grid end tag
  lgs_front #(
    .MAX_LEN (MAX_LEN),
    .RW      (RW),
    .CW      (CW),
    .EW      (EW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_fire),
    .len_i        (len_q),
    .in_valid_i   (in_valid_i),
    .cell_alive_i (cell_alive_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  // queue between the two halves
  lgs_queue #(
    .EW (EW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_fire),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_rdata),
    .pop_i       (q_pop)
  );

  // back: line buffers, window, rule, flush and output register
  lgs_back #(
    .MAX_LEN (MAX_LEN),
    .RW      (RW),
    .CW      (CW),
    .EW      (EW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_fire),
    .len_i        (len_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_alive_o (next_alive_o),
    .grid_last_o  (grid_last_o)
  );

endmodule

// File: hdl/lgs_checker.sv
module lgs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_valid_i,
  input logic cfg_ready_o,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic next_alive_o,
  input logic grid_last_o
);

  // set once any cell beat has been taken
  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(next_alive_o) && $stable(grid_last_o))
    else $error("stalled output beat changed");

  a_out_needs_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q)
    else $error("output beat without any input beat");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind life_generation_stencil_unit lgs_checker u_lgs_checker (.*);
